>>> hdl/lpb_pkg.sv
package lpb_pkg;

	// field widths
	localparam int TIME_W  = 48;
	localparam int LOAD_W  = 7;
	localparam int LEVEL_W = 8;
	localparam int PAT_W   = 3;

	// remainder pipeline: divisor and remainder width, dividend bits per stage
	localparam int DIV_W          = 12;
	localparam int BITS_PER_STAGE = 8;
	localparam int DIV_STAGES     = TIME_W / BITS_PER_STAGE;

	// breathe datapath widths
	localparam int FOLD_W  = 11;
	localparam int SCALE_W = FOLD_W + LEVEL_W;
	localparam int QUOT_W  = SCALE_W - 3;
	localparam int RECIP_W = 17;
	localparam int PROD_W  = QUOT_W + RECIP_W;
	localparam int RECIP_SHIFT = 23;
	localparam int TRI_W   = PROD_W - RECIP_SHIFT;

	typedef enum logic [PAT_W-1:0] {
		PAT_OFF          = 3'd0,
		PAT_SOLID        = 3'd1,
		PAT_BREATHE      = 3'd2,
		PAT_SLOW_BLINK   = 3'd3,
		PAT_FAST_BLINK   = 3'd4,
		PAT_HEARTBEAT    = 3'd5,
		PAT_SLOW_BREATHE = 3'd6,
		PAT_ACTIVITY     = 3'd7
	} pattern_t;

	// side data travelling alongside the dividend
	typedef struct packed {
		pattern_t           pattern;
		logic [DIV_W-1:0]   divisor;
	} side_t;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
	localparam logic [LOAD_W-1:0]  LOAD_MAX   = 7'd100;

	localparam logic [DIV_W-1:0] PER_BREATHE      = 12'd2000;
	localparam logic [DIV_W-1:0] PER_SLOW_BLINK   = 12'd1000;
	localparam logic [DIV_W-1:0] PER_FAST_BLINK   = 12'd400;
	localparam logic [DIV_W-1:0] PER_HEARTBEAT    = 12'd800;
	localparam logic [DIV_W-1:0] PER_SLOW_BREATHE = 12'd4000;

	localparam logic [DIV_W-1:0] ON_SLOW_BLINK = 12'd500;
	localparam logic [DIV_W-1:0] ON_FAST_BLINK = 12'd200;
	localparam logic [DIV_W-1:0] HB_FIRST_END  = 12'd150;
	localparam logic [DIV_W-1:0] HB_SECOND_BEG = 12'd350;
	localparam logic [DIV_W-1:0] HB_SECOND_END = 12'd500;

	localparam logic [FOLD_W-1:0] ACT_BASE  = 11'd2000;
	localparam logic [DIV_W-1:0]  ACT_FLOOR = 12'd200;
	localparam logic [DIV_W-1:0]  ACT_ON    = 12'd100;

	// ceil(2^23 / 125): exact floor division by 125 for any 16-bit value
	localparam logic [RECIP_W-1:0] RECIP_125 = 17'd67109;

	// one radix-2 restoring step per dividend bit, MSB first
	function automatic logic [DIV_W-1:0] rem_step(
		input logic [DIV_W-1:0]          rem,
		input logic [BITS_PER_STAGE-1:0] bits,
		input logic [DIV_W-1:0]          divisor
	);
		logic [DIV_W:0]   acc;
		logic [DIV_W-1:0] r;
		r = rem;
		for (int i = BITS_PER_STAGE - 1; i >= 0; i--) begin
			acc = {r, bits[i]};
			if (acc >= {1'b0, divisor}) begin
				acc = acc - {1'b0, divisor};
			end
			r = acc[DIV_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/lpb_in_if.sv
interface lpb_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [lpb_pkg::TIME_W-1:0]   elapsed_time_ms;
	logic        [lpb_pkg::LOAD_W-1:0]   load_pct;

	modport source (output valid, elapsed_time_ms, load_pct, input ready);
	modport sink   (input valid, elapsed_time_ms, load_pct, output ready);
endinterface

>>> hdl/lpb_out_if.sv
interface lpb_out_if;
	logic                           valid;
	logic                           ready;
	logic [lpb_pkg::LEVEL_W-1:0]    brightness;

	modport source (output valid, brightness, input ready);
	modport sink   (input valid, brightness, output ready);
endinterface

>>> hdl/lpb_cfg_if.sv
interface lpb_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [lpb_pkg::PAT_W-1:0]    pattern_select;

	modport source (output valid, pattern_select, input ready);
	modport sink   (input valid, pattern_select, output ready);
endinterface

>>> hdl/lpb_rem_pipe.sv
module lpb_rem_pipe (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lpb_pkg::TIME_W-1:0]   in_dividend,
	input  lpb_pkg::side_t               in_side,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lpb_pkg::DIV_W-1:0]    out_rem,
	output lpb_pkg::side_t               out_side
);
	import lpb_pkg::*;

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES-1:0] adv;
	logic [DIV_STAGES-1:0] nxt_rdy;
	logic [TIME_W-1:0]     num_s  [DIV_STAGES];
	logic [DIV_W-1:0]      rem_s  [DIV_STAGES];
	side_t                 side_s [DIV_STAGES];

	// a stage takes a new word when empty or when its word moves on
	assign nxt_rdy = {out_ready, adv[DIV_STAGES-1:1]};
	assign adv     = ~vld_s | nxt_rdy;
	assign in_ready = adv[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic              src_vld;
		logic [TIME_W-1:0] src_num;
		logic [DIV_W-1:0]  src_rem;
		side_t             src_side;

		if (k == 0) begin : g_first
			assign src_vld  = in_valid;
			assign src_num  = in_dividend;
			assign src_rem  = '0;
			assign src_side = in_side;
		end else begin : g_next
			assign src_vld  = vld_s[k-1];
			assign src_num  = num_s[k-1];
			assign src_rem  = rem_s[k-1];
			assign src_side = side_s[k-1];
		end

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		// eight dividend bits folded into the remainder per stage
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				num_s[k]  <= src_num;
				side_s[k] <= src_side;
				rem_s[k]  <= rem_step(src_rem,
					src_num[TIME_W-1-k*BITS_PER_STAGE -: BITS_PER_STAGE],
					src_side.divisor);
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign out_rem   = rem_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rem < out_side.divisor)
		else $error("remainder not below divisor");

	a_divisor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> side_s[0].divisor >= ACT_FLOOR)
		else $error("divisor below floor in first stage");

	a_divisor_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_side.divisor <= PER_SLOW_BREATHE)
		else $error("divisor above longest period");

endmodule

>>> hdl/led_pattern_brightness_core.sv
// An accepted sample word passes to its brightness word at the output through
//   1 input register, 6 remainder stages (8 time bits each), 3 shaping stages.
// Throughput: one word per cycle while the output is ready; a stalled output holds only
// the stages behind it full. The time-modulo-period remainder pipeline sets the depth.
// Reset: all valid bits clear and the pattern register returns to off.
module led_pattern_brightness_core (
	input  logic          clk,
	input  logic          arst_n,
	lpb_in_if.sink        sample,
	lpb_out_if.source     result,
	lpb_cfg_if.sink       cfg
);
	import lpb_pkg::*;

	pattern_t pattern_q;

	// configuration register, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PAT_OFF;
		end else if (cfg.valid) begin
			pattern_q <= pattern_t'(cfg.pattern_select);
		end
	end

	// handshake chain
	logic adv_s1, adv_s2, adv_s3, adv_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic div_in_ready;
	logic div_out_valid;
	logic [DIV_W-1:0] div_rem;
	side_t div_side;

	assign adv_s4 = !v_s4 || result.ready;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || div_in_ready;
	assign sample.ready = adv_s1;

	// stage 1 input: clamp time, saturate load, choose period
	logic [TIME_W-1:0] time_clamped;
	logic [LOAD_W-1:0] load_sat;
	logic [FOLD_W-1:0] load_x18;
	logic [FOLD_W-1:0] act_raw;
	logic [DIV_W-1:0]  act_period;
	side_t             side_in;

	assign time_clamped = sample.elapsed_time_ms[TIME_W-1] ? '0
		: TIME_W'(unsigned'(sample.elapsed_time_ms));
	assign load_sat = (sample.load_pct > LOAD_MAX) ? LOAD_MAX : sample.load_pct;
	assign load_x18 = {load_sat, 4'b0000} + {3'b000, load_sat, 1'b0};
	assign act_raw  = ACT_BASE - load_x18;
	assign act_period = ({1'b0, act_raw} < ACT_FLOOR) ? ACT_FLOOR : {1'b0, act_raw};

	always_comb begin
		side_in.pattern = pattern_q;
		case (pattern_q)
			PAT_SLOW_BLINK:   side_in.divisor = PER_SLOW_BLINK;
			PAT_FAST_BLINK:   side_in.divisor = PER_FAST_BLINK;
			PAT_HEARTBEAT:    side_in.divisor = PER_HEARTBEAT;
			PAT_SLOW_BREATHE: side_in.divisor = PER_SLOW_BREATHE;
			PAT_ACTIVITY:     side_in.divisor = act_period;
			default:          side_in.divisor = PER_BREATHE;
		endcase
	end

	logic [TIME_W-1:0] time_s1;
	side_t             side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			time_s1 <= time_clamped;
			side_s1 <= side_in;
		end
	end

	// time modulo period
	lpb_rem_pipe u_rem (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s1),
		.in_ready    (div_in_ready),
		.in_dividend (time_s1),
		.in_side     (side_s1),
		.out_valid   (div_out_valid),
		.out_ready   (adv_s2),
		.out_rem     (div_rem),
		.out_side    (div_side)
	);

	// stage 2: triangle fold, scale by 255/8, on/off decision
	logic [DIV_W-1:0]   half;
	logic [FOLD_W-1:0]  fold;
	logic [SCALE_W-1:0] scaled;
	logic               on_d;

	assign half = div_side.divisor >> 1;
	assign fold = (div_rem <= half) ? div_rem[FOLD_W-1:0]
		: FOLD_W'(div_side.divisor - div_rem);
	assign scaled = {fold, 8'b0000_0000} - {8'b0000_0000, fold};

	always_comb begin
		case (div_side.pattern)
			PAT_SLOW_BLINK: on_d = div_rem < ON_SLOW_BLINK;
			PAT_FAST_BLINK: on_d = div_rem < ON_FAST_BLINK;
			PAT_HEARTBEAT:  on_d = (div_rem < HB_FIRST_END)
				|| ((div_rem >= HB_SECOND_BEG) && (div_rem < HB_SECOND_END));
			PAT_ACTIVITY:   on_d = div_rem < ACT_ON;
			default:        on_d = 1'b0;
		endcase
	end

	pattern_t          pattern_s2;
	logic [QUOT_W-1:0] quot8_s2;
	logic              on_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pattern_s2 <= div_side.pattern;
			quot8_s2   <= scaled[SCALE_W-1:3];
			on_s2      <= on_d;
		end
	end

	// stage 3: divide by 125 through the reciprocal
	pattern_t          pattern_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              on_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			pattern_s3 <= pattern_s2;
			prod_s3    <= PROD_W'(quot8_s2) * PROD_W'(RECIP_125);
			on_s3      <= on_s2;
		end
	end

	// stage 4: select the level
	logic [TRI_W-1:0]   tri_q;
	logic [LEVEL_W-1:0] level_d;
	logic [LEVEL_W-1:0] brightness_s4;
	pattern_t           pattern_s4;

	assign tri_q = prod_s3[PROD_W-1:RECIP_SHIFT];

	always_comb begin
		case (pattern_s3)
			PAT_OFF:          level_d = '0;
			PAT_SOLID:        level_d = FULL_LEVEL;
			PAT_BREATHE:      level_d = tri_q[LEVEL_W-1:0];
			PAT_SLOW_BREATHE: level_d = tri_q[LEVEL_W:1];
			default:          level_d = on_s3 ? FULL_LEVEL : '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			brightness_s4 <= level_d;
			pattern_s4    <= pattern_s3;
		end
	end

	assign result.valid      = v_s4;
	assign result.brightness = brightness_s4;

	a_off_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && pattern_s4 == PAT_OFF) |-> result.brightness == '0)
		else $error("off pattern gave a lit word");

	a_breathe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && pattern_s3 == PAT_BREATHE) |-> tri_q <= TRI_W'(FULL_LEVEL))
		else $error("breathe level above full");

	a_no_blink_for_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (pattern_s2 == PAT_OFF || pattern_s2 == PAT_SOLID)) |-> !on_s2)
		else $error("on flag set for a steady pattern");

endmodule
